// ----- hw/rtl/rcf_pkg.sv -----
package rcf_pkg;

   localparam int RC_BITS        = 32;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [RC_BITS-1:0] RC_RESET = 32'd1000;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILTER_MODE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RC_TICKS    = 1'b1;

   localparam logic MODE_LOW_PASS  = 1'b0;
   localparam logic MODE_HIGH_PASS = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DT,
      S_DEN,
      S_DIVGO,
      S_DIVWAIT,
      S_MUL0,
      S_MUL1,
      S_ACC,
      S_FIN
   } rcf_state_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic       load;
      acc_op_type acc_op;
   } mac_ctrl_type;

endpackage

// ----- hw/rtl/rcf_divider.sv -----
module rcf_divider #(
   parameter int FRAC_BITS = 16,
   parameter int DEN_BITS  = 33
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DEN_BITS-1:0]  num,
   input  logic [DEN_BITS-1:0]  den,
   output logic [FRAC_BITS:0]   q,
   output logic                 done
);

   localparam int CNT_BITS = $clog2(FRAC_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(FRAC_BITS - 1);
   localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [DEN_BITS-1:0]  r_ff, r_in;
   logic [FRAC_BITS:0]   q_ff, q_in;

   logic [DEN_BITS:0]    r_dbl;
   logic [DEN_BITS:0]    den_x;
   logic [DEN_BITS:0]    r_sub;
   logic                 ge;

   // one restoring step per cycle; den is held by the caller until done
   always_comb begin
      r_dbl = {r_ff, 1'b0};
      den_x = {1'b0, den};
      r_sub = r_dbl - den_x;
      ge    = (r_dbl >= den_x);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      if (start) begin
         if ((den == '0) || (num >= den)) begin
            q_in    = ONE_Q;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            r_in    = num;
            q_in    = '0;
            cnt_in  = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         r_in   = ge ? r_sub[DEN_BITS-1:0] : r_dbl[DEN_BITS-1:0];
         q_in   = {q_ff[FRAC_BITS-1:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
   end

   assign q    = q_ff;
   assign done = done_ff;

endmodule

// ----- hw/rtl/rcf_mac.sv -----
module rcf_mac #(
   parameter int SAMPLE_BITS = 24,
   parameter int FRAC_BITS   = 16,
   parameter int AW          = 18,
   parameter int OW          = 26
) (
   input  logic                          clock,
   input  rcf_pkg::mac_ctrl_type         ctrl,
   input  logic signed [AW-1:0]          op_a,
   input  logic signed [OW-1:0]          op_b,
   output logic signed [SAMPLE_BITS-1:0] result
);

   import rcf_pkg::*;

   localparam int PW  = AW + OW;
   localparam int ACW = PW + 1;

   localparam logic signed [ACW-1:0] HALF =
      {{(ACW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
   localparam logic signed [ACW-1:0] SAT_MAX =
      {{(ACW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [ACW-1:0] SAT_MIN =
      {{(ACW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [PW-1:0]  prod_ff, prod_in;
   logic signed [ACW-1:0] acc_ff, acc_in;
   logic signed [ACW-1:0] prod_x;
   logic signed [ACW-1:0] acc_rnd;
   logic signed [ACW-1:0] acc_q;

   always_comb begin
      prod_in = prod_ff;
      if (ctrl.load) begin
         prod_in = op_a * op_b;
      end
   end

   always_comb begin
      prod_x = {prod_ff[PW-1], prod_ff};
      unique case (ctrl.acc_op)
         ACC_LOAD: acc_in = prod_x;
         ACC_ADD:  acc_in = acc_ff + prod_x;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // round half up, then clamp to the sample range
   always_comb begin
      acc_rnd = acc_ff + HALF;
      acc_q   = acc_rnd >>> FRAC_BITS;
      if (acc_q > SAT_MAX) begin
         result = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (acc_q < SAT_MIN) begin
         result = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         result = acc_q[SAMPLE_BITS-1:0];
      end
   end

endmodule

// ----- hw/rtl/rc_filter_variable_step_unit.sv -----
// channel  | direction | handshake            | payload
// req      | in        | req_valid/req_stall  | req_sample, req_timestamp, req_first
// rsp      | out       | rsp_valid/rsp_stall  | rsp_filtered
// csr      | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// a continuing word goes through the restoring divider, one quotient bit per cycle;
// the divider skips its bit steps and returns one when alpha is plainly one
// a word flagged first goes from S_DT to S_FIN, skipping the divider and multiplier
// req_stall is high from acceptance until the result moves to the output register
// a stalled result stays in the output register while the next word is taken
// reset is synchronous; state, mode, history and rsp_valid come up cleared, rc at 1000
module rc_filter_variable_step_unit #(
   parameter int SAMPLE_BITS     = 24,
   parameter int TIME_BITS       = 32,
   parameter int ALPHA_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,
   input  logic [TIME_BITS-1:0]                 req_timestamp,
   input  logic                                 req_first,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]        rsp_filtered,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rcf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rcf_pkg::RC_BITS-1:0]          csr_data
);

   import rcf_pkg::*;

   localparam int DEN_BITS = ((TIME_BITS > RC_BITS) ? TIME_BITS : RC_BITS) + 1;
   localparam int AW       = ALPHA_FRAC_BITS + 2;
   localparam int OW       = SAMPLE_BITS + 2;
   localparam logic signed [AW-1:0] ONE_A = {2'b01, {ALPHA_FRAC_BITS{1'b0}}};
   localparam logic [ALPHA_FRAC_BITS:0] ONE_Q = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};

   rcf_state_type state_ff, state_in;

   logic                          mode_ff, mode_in;
   logic [RC_BITS-1:0]            rc_ff, rc_in;

   logic [TIME_BITS-1:0]          last_time_ff;
   logic signed [SAMPLE_BITS-1:0] last_input_ff;
   logic signed [SAMPLE_BITS-1:0] last_output_ff;

   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic [TIME_BITS-1:0]          ts_ff;
   logic                          first_ff;
   logic [TIME_BITS-1:0]          dt_ff;
   logic signed [OW-1:0]          diff_ff;
   logic [DEN_BITS-1:0]           den_ff;
   logic [DEN_BITS-1:0]           num_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered_ff;

   logic                          req_take;
   logic                          out_free;
   logic                          fin_go;
   logic                          div_start;
   logic [ALPHA_FRAC_BITS:0]      div_q;
   logic                          div_done;
   mac_ctrl_type                  mac_ctrl;
   logic signed [AW-1:0]          op_a;
   logic signed [OW-1:0]          op_b;
   logic signed [AW-1:0]          a_ext;
   logic signed [OW-1:0]          x_ext;
   logic signed [OW-1:0]          yprev_ext;
   logic signed [SAMPLE_BITS-1:0] mac_result;
   logic signed [SAMPLE_BITS-1:0] y_final;

   rcf_divider #(
      .FRAC_BITS (ALPHA_FRAC_BITS),
      .DEN_BITS  (DEN_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .q     (div_q),
      .done  (div_done)
   );

   rcf_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (ALPHA_FRAC_BITS),
      .AW          (AW),
      .OW          (OW)
   ) u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .op_a   (op_a),
      .op_b   (op_b),
      .result (mac_result)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_take = req_valid && !req_stall;
   assign fin_go   = (state_ff == S_FIN) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_valid) state_in = S_DT;
         S_DT:      state_in = first_ff ? S_FIN : S_DEN;
         S_DEN:     state_in = S_DIVGO;
         S_DIVGO:   state_in = S_DIVWAIT;
         S_DIVWAIT: if (div_done) state_in = S_MUL0;
         S_MUL0:    state_in = S_MUL1;
         S_MUL1:    state_in = S_ACC;
         S_ACC:     state_in = S_FIN;
         S_FIN:     if (out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      a_ext     = {1'b0, div_q};
      x_ext     = {{2{x_ff[SAMPLE_BITS-1]}}, x_ff};
      yprev_ext = {{2{last_output_ff[SAMPLE_BITS-1]}}, last_output_ff};
      req_stall = (state_ff != S_IDLE);
      div_start = (state_ff == S_DIVGO);
      mac_ctrl  = '{load: 1'b0, acc_op: ACC_HOLD};
      op_a      = '0;
      op_b      = '0;
      unique case (state_ff)
         S_MUL0: begin
            mac_ctrl.load = 1'b1;
            op_a          = a_ext;
            op_b          = (mode_ff == MODE_HIGH_PASS) ? diff_ff : x_ext;
         end
         S_MUL1: begin
            mac_ctrl.load   = 1'b1;
            mac_ctrl.acc_op = ACC_LOAD;
            // high-pass has a single term, so the second product is zero
            op_a = (mode_ff == MODE_HIGH_PASS) ? a_ext : (ONE_A - a_ext);
            op_b = (mode_ff == MODE_HIGH_PASS) ? '0 : yprev_ext;
         end
         S_ACC: begin
            mac_ctrl.acc_op = ACC_ADD;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (first_ff) begin
         y_final = (mode_ff == MODE_HIGH_PASS) ? '0 : x_ff;
      end else begin
         y_final = mac_result;
      end
   end

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      rc_in   = rc_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FILTER_MODE: mode_in = csr_data[0];
            CSR_RC_TICKS:    rc_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fin_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         mode_ff        <= MODE_LOW_PASS;
         rc_ff          <= RC_RESET;
         rsp_valid_ff   <= 1'b0;
         last_time_ff   <= '0;
         last_input_ff  <= '0;
         last_output_ff <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rc_ff        <= rc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fin_go) begin
            last_time_ff   <= ts_ff;
            last_input_ff  <= x_ff;
            last_output_ff <= y_final;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff     <= req_sample;
         ts_ff    <= req_timestamp;
         first_ff <= req_first;
      end
      if (state_ff == S_DT) begin
         dt_ff   <= ts_ff - last_time_ff;
         diff_ff <= yprev_ext + x_ext - {{2{last_input_ff[SAMPLE_BITS-1]}}, last_input_ff};
      end
      if (state_ff == S_DEN) begin
         den_ff <= DEN_BITS'(rc_ff) + DEN_BITS'(dt_ff);
         num_ff <= (mode_ff == MODE_HIGH_PASS) ? DEN_BITS'(rc_ff) : DEN_BITS'(dt_ff);
      end
      if (fin_go) begin
         rsp_filtered_ff <= y_final;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIVWAIT))
      else $error("divider finished outside its wait state");

   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (div_q <= ONE_Q))
      else $error("alpha above one");

   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_DT))
      else $error("accepted word did not start the sequence");

   a_state_follows_out: assert property (@(posedge clock) disable iff (reset)
      fin_go |=> (rsp_valid_ff && (last_output_ff == rsp_filtered_ff)))
      else $error("stored output differs from delivered word");

endmodule
